@@ src/wlp_pkg.sv @@
// shared types and constants of the weighted lottery pick
`timescale 1ns / 1ps
`default_nettype none
package wlp_pkg;

  // field and register widths
  localparam int unsigned WeightW  = 8;
  localparam int unsigned RandW    = 31;
  localparam int unsigned SlotIdxW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumRegs  = 8;
  // eight weights of 255 sum to at most 2040
  localparam int unsigned SumW     = 11;
  localparam int unsigned BitCntW  = 5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SEL,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

@@ src/weighted_lottery_pick_no_repeat.sv @@
// weighted lottery pick over weighted slots, repeating a slot only if no other has weight
`timescale 1ns / 1ps
`default_nettype none
// Weighted lottery pick. Each request word carries a 31-bit random number; the block
// sums the weights of all slots except the previous pick (all slots if that sum is
// zero), reduces the random number modulo that sum with a bit-serial restoring
// divider and walks the cumulative weights one slot per cycle to find the pick.
// One item passes through the accept in idle, a sweep over all SLOTS slots summing the
// weights, a select step, the divider loop (one quotient bit per step, one step per bit
// of the random word) and a walk over at most SLOTS slots, both skipped if every weight
// is zero, then the done state, which loads the output register once it is free. A new
// word is taken in idle, even while the previous result still waits in the output register.
// found_o is 0 and chosen_slot_o is 0 when every weight is zero. The user must write weights
// through the configuration port only while the block is idle; no logic in the block enforces this.
module weighted_lottery_pick_no_repeat #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [wlp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [wlp_pkg::WeightW-1:0]    cfg_data_i,
  // request words
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [wlp_pkg::RandW-1:0]      random_word_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [wlp_pkg::SlotIdxW-1:0]        chosen_slot_o,
  output logic                                found_o
);
  import wlp_pkg::*;

  localparam logic [SlotIdxW-1:0] LastSlot = SlotIdxW'(SLOTS - 1);
  localparam logic [BitCntW-1:0]  LastBit  = BitCntW'(RandW - 1);

  state_e state_q, state_d;

  logic [WeightW-1:0]  weight_q [NumRegs];
  logic                last_valid_q;
  logic [SlotIdxW-1:0] last_slot_q;

  logic [SlotIdxW-1:0] cnt_q;
  logic [BitCntW-1:0]  bit_cnt_q;
  logic [SumW-1:0]     sum_all_q;
  logic [SumW-1:0]     sum_skip_q;
  logic [SumW-1:0]     total_q;
  logic                skip_q;
  logic [RandW-1:0]    rnd_q;
  logic [SumW-1:0]     rem_q;
  logic [SumW-1:0]     acc_q;
  logic [SlotIdxW-1:0] pick_q;
  logic                found_q;

  logic                out_valid_q;
  logic [SlotIdxW-1:0] out_slot_q;
  logic                out_found_q;

  logic [WeightW-1:0]  cur_w;
  logic                is_last;
  logic [SumW:0]       rem_sh;
  logic                rem_ge;
  logic [SumW-1:0]     rem_d;
  logic [SumW:0]       acc_w;
  logic                walk_hit;
  logic                out_free;

  // weight of the slot under the sweep counter
  assign cur_w   = weight_q[cnt_q];
  assign is_last = (cnt_q == last_slot_q);

  // one restoring divider step
  assign rem_sh = {rem_q, rnd_q[RandW-1]};
  assign rem_ge = (rem_sh >= {1'b0, total_q});
  assign rem_d  = rem_ge ? SumW'(rem_sh - {1'b0, total_q}) : rem_sh[SumW-1:0];

  // cumulative weight compare during the walk
  assign acc_w    = {1'b0, acc_q} + (SumW + 1)'(cur_w);
  assign walk_hit = !(skip_q && is_last) && ({1'b0, rem_q} < acc_w);

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign chosen_slot_o = out_slot_q;
  assign found_o       = out_found_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (cnt_q == LastSlot) state_d = ST_SEL;
      end
      ST_SEL: begin
        state_d = (sum_all_q == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt_q == LastBit) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_hit || cnt_q == LastSlot) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // weight registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) weight_q[i] <= '0;
    end else if (cfg_we_i) begin
      weight_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // previous pick and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
      last_slot_q  <= '0;
      out_valid_q  <= 1'b0;
      out_slot_q   <= '0;
      out_found_q  <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        out_slot_q   <= found_q ? pick_q : '0;
        out_found_q  <= found_q;
        last_valid_q <= found_q;
        if (found_q) last_slot_q <= pick_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath: sum sweep, divider, walk
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cnt_q      <= '0;
        sum_all_q  <= '0;
        sum_skip_q <= '0;
        rnd_q      <= random_word_i;
      end
      ST_SUM: begin
        cnt_q     <= cnt_q + 1'b1;
        sum_all_q <= sum_all_q + SumW'(cur_w);
        if (!(last_valid_q && is_last)) sum_skip_q <= sum_skip_q + SumW'(cur_w);
      end
      ST_SEL: begin
        skip_q    <= last_valid_q && (sum_skip_q != '0);
        total_q   <= (last_valid_q && (sum_skip_q != '0)) ? sum_skip_q : sum_all_q;
        found_q   <= (sum_all_q != '0);
        rem_q     <= '0;
        bit_cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q     <= rem_d;
        rnd_q     <= {rnd_q[RandW-2:0], 1'b0};
        bit_cnt_q <= bit_cnt_q + 1'b1;
        cnt_q     <= '0;
        acc_q     <= '0;
      end
      ST_WALK: begin
        pick_q <= cnt_q;
        cnt_q  <= cnt_q + 1'b1;
        if (!(skip_q && is_last)) acc_q <= acc_w[SumW-1:0];
      end
      ST_DONE: begin
        cnt_q <= '0;
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  // an accepted word leaves the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  // the divider remainder stays below the total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_WALK) |-> (rem_q < total_q))
    else $error("remainder not below total");

  // an empty result carries slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_slot_q == '0))
    else $error("empty result with nonzero slot");

  // the remembered pick lies within the active slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_valid_q |-> (last_slot_q <= LastSlot))
    else $error("previous pick out of range");

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench of the weighted lottery pick block
`timescale 1ns / 1ps
module testbench;
  import wlp_pkg::*;

  localparam int unsigned Slots = 8;

  // pick expected for one request word
  typedef struct packed {
    logic [SlotIdxW-1:0] slot;
    logic                found;
  } pick_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [WeightW-1:0]  cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [RandW-1:0]    random_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SlotIdxW-1:0] chosen_slot_o;
  logic                found_o;

  // weights as programmed, and the no-repeat memory of the block
  logic [WeightW-1:0]  weight_m [NumRegs];
  logic [WeightW-1:0]  weight_plan [NumRegs];
  logic                prev_valid_m;
  logic [SlotIdxW-1:0] prev_slot_m;

  pick_t pick_q [$];
  int    err_cnt;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    hold_req;

  weighted_lottery_pick_no_repeat #(
    .SLOTS(Slots)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .random_word_i (random_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .chosen_slot_o (chosen_slot_o),
    .found_o       (found_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // sum of slot weights, optionally leaving out the previous pick
  function automatic int unsigned weight_sum(input bit skip_prev);
    int unsigned total;
    total = 0;
    for (int i = 0; i < Slots; i++) begin
      if (!(skip_prev && i == prev_slot_m)) total += weight_m[i];
    end
    return total;
  endfunction

  // predicted result of one request, updating the no-repeat memory
  function automatic pick_t predict_pick(input logic [RandW-1:0] word);
    int unsigned total;
    int unsigned rem;
    int unsigned acc;
    bit          skip;
    bit          hit;
    pick_t       res;
    res   = '0;
    skip  = prev_valid_m;
    total = weight_sum(skip);
    // only the previous pick has weight: forget it and use all slots
    if (total == 0) begin
      prev_valid_m = 1'b0;
      skip         = 1'b0;
      total        = weight_sum(1'b0);
    end
    // nothing available
    if (total == 0) return res;
    rem = word % total;
    acc = 0;
    hit = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      if (!hit && !(skip && i == prev_slot_m)) begin
        if (rem < acc + weight_m[i]) begin
          res.slot = i[SlotIdxW-1:0];
          hit      = 1'b1;
        end
        acc += weight_m[i];
      end
    end
    res.found    = 1'b1;
    prev_slot_m  = res.slot;
    prev_valid_m = 1'b1;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_result
    pick_t exp_pick;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pick_q.size() == 0) begin
        $error("result word with none expected: chosen_slot %0d found %0d",
               chosen_slot_o, found_o);
        err_cnt++;
      end else begin
        exp_pick = pick_q.pop_front();
        if (chosen_slot_o !== exp_pick.slot) begin
          $error("chosen_slot: expected %0d, got %0d", exp_pick.slot, chosen_slot_o);
          err_cnt++;
        end
        if (found_o !== exp_pick.found) begin
          $error("found: expected %0d, got %0d", exp_pick.found, found_o);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one request word and wait for it to be taken; starts and ends after a falling edge
  task automatic send_word(input logic [RandW-1:0] word);
    bit taken;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_word_i <= word;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (in_ready_o) begin
        taken = 1'b1;
        pick_q.push_back(predict_pick(word));
      end
      @(negedge clk_i);
    end
  endtask

  // sender pauses until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pick_q.size() != 0) @(negedge clk_i);
  endtask

  // write all weights from the plan; block must be idle
  task automatic program_weights();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[CfgIdxW-1:0];
      cfg_data_i <= weight_plan[i];
      weight_m[i] = weight_plan[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic fill_plan(input logic [WeightW-1:0] w);
    for (int i = 0; i < NumRegs; i++) weight_plan[i] = w;
  endtask

  // random weight set: empty, single slot, full, or a mix
  task automatic randomize_plan();
    int mode;
    int k;
    mode = $urandom_range(0, 15);
    if (mode == 0) begin
      fill_plan('0);
    end else if (mode == 1) begin
      fill_plan('0);
      weight_plan[CfgIdxW'($urandom_range(0, NumRegs - 1))] =
        WeightW'($urandom_range(1, 255));
    end else if (mode == 2) begin
      fill_plan(8'hff);
    end else begin
      for (int i = 0; i < NumRegs; i++) begin
        k = $urandom_range(0, 7);
        if (k < 2)       weight_plan[i] = '0;
        else if (k == 2) weight_plan[i] = 8'hff;
        else if (k == 3) weight_plan[i] = 8'd1;
        else             weight_plan[i] = WeightW'($urandom_range(0, 255));
      end
    end
  endtask

  function automatic logic [RandW-1:0] rand_word();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 4)  return RandW'($urandom_range(0, 4095));
    return RandW'($urandom);
  endfunction

  // all slots empty: nothing available
  task automatic test_empty_slots();
    fill_plan('0);
    program_weights();
    send_word('0);
    send_word('1);
    drain_results();
  endtask

  // one slot with weight: the previous pick is forgotten and repeats
  task automatic test_single_slot();
    fill_plan('0);
    weight_plan[3] = 8'd1;
    program_weights();
    send_word('0);
    send_word('1);
    send_word(31'h2aaa_5555);
    drain_results();
  endtask

  // all weights at maximum, words at and around the cumulative bounds
  task automatic test_extreme_weights();
    fill_plan(8'hff);
    program_weights();
    send_word('0);
    send_word(31'd254);
    send_word(31'd255);
    send_word(31'd1784);
    send_word(31'd1785);
    send_word('1);
    drain_results();
  endtask

  // two slots alternate, then everything empty clears the memory, then a fresh pair of slots
  task automatic test_no_repeat();
    fill_plan('0);
    weight_plan[0] = 8'hff;
    weight_plan[7] = 8'd1;
    program_weights();
    send_word('0);
    send_word('0);
    send_word('0);
    send_word('1);
    drain_results();
    fill_plan('0);
    program_weights();
    send_word(31'h5555_2aaa);
    drain_results();
    weight_plan[5] = 8'd200;
    weight_plan[6] = 8'd1;
    program_weights();
    send_word(31'd199);
    send_word(31'd199);
    drain_results();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    randomize_plan();
    program_weights();
    hold_req = 400;
    for (int n = 0; n < 12; n++) send_word(rand_word());
    drain_results();
    for (int n = 0; n < 8; n++) send_word(rand_word());
    drain_results();
  endtask

  // random words under one idling pattern, new weights every few dozen words
  task automatic test_random_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        drain_results();
        randomize_plan();
        program_weights();
      end
      send_word(rand_word());
    end
    drain_results();
  endtask

  initial begin
    err_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    prev_valid_m   = 1'b0;
    prev_slot_m    = '0;
    for (int i = 0; i < NumRegs; i++) weight_m[i] = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    random_word_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_slots();
    test_single_slot();
    test_extreme_weights();
    test_no_repeat();
    test_output_stall();
    test_random_phase(250, 0, 0);
    test_random_phase(250, 49, 0);
    test_random_phase(250, 0, 49);
    test_random_phase(250, 19, 19);

    repeat (60) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ weighted_lottery_pick_no_repeat.f @@
src/wlp_pkg.sv
src/weighted_lottery_pick_no_repeat.sv
verif/testbench.sv
